// File: rtl/core/priority_periodic_task_dispatcher_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros shared by the dispatcher RTL
// Clocked on clk, silenced while rst is high.
// ----------------------------------------------------------------------------
`ifndef PRIORITY_PERIODIC_TASK_DISPATCHER_UNIT_DEFINES_SVH
`define PRIORITY_PERIODIC_TASK_DISPATCHER_UNIT_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define PPT_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define PPT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/ppt_pkg.sv
// ----------------------------------------------------------------------------
// ppt_pkg
// Item types and codes of the priority periodic task dispatcher.
// ----------------------------------------------------------------------------
`default_nettype none

package ppt_pkg;

  // action codes of an input item
  localparam logic [1:0] ACT_TICK   = 2'd0;
  localparam logic [1:0] ACT_CREATE = 2'd1;
  localparam logic [1:0] ACT_SET    = 2'd2;
  localparam logic [1:0] ACT_NONE   = 2'd3;

  // result kinds
  localparam logic [1:0] KIND_ACK  = 2'd0;
  localparam logic [1:0] KIND_FIRE = 2'd1;
  localparam logic [1:0] KIND_ERR  = 2'd2;

  // result status codes
  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_FULL    = 2'd1;
  localparam logic [1:0] STAT_UNKNOWN = 2'd2;

  // at most this many fired results per tick
  localparam int MAX_RESULTS = 8;
  localparam int EMIT_W      = $clog2(MAX_RESULTS);

  // command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] priority_req;
    logic [7:0] period;
    logic [2:0] task_id;
  } in_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [2:0] fired_task;
    logic [1:0] status;
    logic       last;
  } out_item_t;

  // classified command as queued for the back end
  typedef struct packed {
    logic [1:0] op;
    logic [7:0] prio;
    logic [7:0] period;
    logic [2:0] id;
  } cmd_t;

  // queue head as seen by the back end
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } queue_head_t;

endpackage

`default_nettype wire

// File: rtl/core/ppt_front.sv
// ----------------------------------------------------------------------------
// ppt_front
// Accepts items, drops unused actions and queues commands for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module ppt_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cmd_valid,
  output logic                   cmd_ready,
  input  wire ppt_pkg::in_item_t cmd,
  output ppt_pkg::queue_head_t   head,
  input  wire logic              pop
);
  import ppt_pkg::*;

  cmd_t               q_data [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  q_count;
  logic [QCNT_W-1:0]  q_count_next;
  logic               push;
  logic               do_pop;
  cmd_t               cmd_class;

  // room in the queue means the item can be taken
  assign cmd_ready = (q_count != QCNT_W'(QUEUE_DEPTH));

  // unused action is taken and dropped
  assign push   = cmd_valid && cmd_ready && (cmd.action != ACT_NONE);
  assign do_pop = pop && (q_count != '0);

  // classify the item into a command
  always_comb begin
    cmd_class.op     = cmd.action;
    cmd_class.prio   = cmd.priority_req;
    cmd_class.period = cmd.period;
    cmd_class.id     = cmd.task_id;
  end

  // occupancy update
  always_comb begin
    case ({push, do_pop})
      2'b10:   q_count_next = q_count + QCNT_W'(1);
      2'b01:   q_count_next = q_count - QCNT_W'(1);
      default: q_count_next = q_count;
    endcase
  end

  // pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      q_count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      q_count <= q_count_next;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_data[wr_ptr] <= cmd_class;
    end
  end

  assign head.valid = (q_count != '0);
  assign head.cmd   = q_data[rd_ptr];

endmodule

`default_nettype wire

// File: rtl/core/ppt_back.sv
// ----------------------------------------------------------------------------
// ppt_back
// Task table, tick engine and result register of the dispatcher.
// ----------------------------------------------------------------------------
`default_nettype none

`include "priority_periodic_task_dispatcher_unit_defines.svh"

module ppt_back #(
  parameter int MAX_TASKS = 8
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire ppt_pkg::queue_head_t head,
  output logic                      pop,
  output logic                      res_valid,
  input  wire logic                 res_ready,
  output ppt_pkg::out_item_t        res
);
  import ppt_pkg::*;

  localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CNT_W = $clog2(MAX_TASKS + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [7:0]           task_prio      [MAX_TASKS];
  logic [7:0]           task_period    [MAX_TASKS];
  logic [7:0]           task_countdown [MAX_TASKS];
  logic [CNT_W-1:0]     task_count;

  logic [1:0]           state;
  logic [MAX_TASKS-1:0] remain;
  logic [MAX_TASKS-1:0] fired;
  logic [MAX_TASKS-1:0] remain_after;
  logic [IDX_W-1:0]     cursor;
  logic [IDX_W-1:0]     best_id;
  logic [7:0]           best_prio;
  logic                 best_valid;
  logic [EMIT_W-1:0]    emitted;

  logic                 out_free;
  logic                 full;
  logic                 id_unknown;
  logic                 take;
  logic                 emit_last;
  logic                 do_emit;
  logic                 ack_pop;

  assign out_free   = !res_valid || res_ready;
  assign pop        = (state == ST_IDLE) && head.valid && out_free;
  assign full       = (task_count == CNT_W'(MAX_TASKS));
  assign id_unknown = ({2'b00, head.cmd.id} >= 5'(task_count));

  // tasks due on this tick
  always_comb begin
    for (int i = 0; i < MAX_TASKS; i++) begin
      fired[i] = (CNT_W'(i) < task_count) && (task_countdown[i] == 8'd0);
    end
  end

  // single reply item: create, set, or a tick where nothing fires
  assign ack_pop = pop && !(head.cmd.op == ACT_TICK && fired != '0);

  // candidate at the scan cursor beats the best so far
  assign take = remain[cursor] && (!best_valid || (task_prio[cursor] > best_prio));

  // emit step of the ordered dispatch
  assign remain_after = remain & ~(MAX_TASKS'(1) << best_id);
  assign emit_last    = (remain_after == '0) || (emitted == EMIT_W'(MAX_RESULTS - 1));
  assign do_emit      = (state == ST_EMIT) && out_free;

  // control: sequencer and task count
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      task_count <= '0;
      remain     <= '0;
      cursor     <= '0;
      best_valid <= 1'b0;
      emitted    <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (pop) begin
            if (head.cmd.op == ACT_CREATE && !full) begin
              task_count <= task_count + CNT_W'(1);
            end
            if (head.cmd.op == ACT_TICK && fired != '0) begin
              remain     <= fired;
              cursor     <= '0;
              best_valid <= 1'b0;
              emitted    <= '0;
              state      <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (take) begin
            best_valid <= 1'b1;
          end
          cursor <= cursor + IDX_W'(1);
          if (cursor == IDX_W'(MAX_TASKS - 1)) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (do_emit) begin
            remain     <= remain_after;
            emitted    <= emitted + EMIT_W'(1);
            cursor     <= '0;
            best_valid <= 1'b0;
            state      <= emit_last ? ST_IDLE : ST_SCAN;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // best candidate of the current scan
  always_ff @(posedge clk) begin
    if (state == ST_SCAN && take) begin
      best_id   <= cursor;
      best_prio <= task_prio[cursor];
    end
  end

  // task table writes
  always_ff @(posedge clk) begin
    if (pop && head.cmd.op == ACT_CREATE && !full) begin
      task_prio[IDX_W'(task_count)]      <= head.cmd.prio;
      task_period[IDX_W'(task_count)]    <= head.cmd.period;
      task_countdown[IDX_W'(task_count)] <= head.cmd.period;
    end
    if (pop && head.cmd.op == ACT_SET && !id_unknown) begin
      task_prio[IDX_W'(head.cmd.id)] <= head.cmd.prio;
    end
    if (pop && head.cmd.op == ACT_TICK) begin
      for (int i = 0; i < MAX_TASKS; i++) begin
        if (CNT_W'(i) < task_count) begin
          task_countdown[i] <= fired[i] ? task_period[i] : task_countdown[i] - 8'd1;
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else begin
      if (res_ready) begin
        res_valid <= 1'b0;
      end
      if (ack_pop) begin
        res_valid <= 1'b1;
      end
      if (do_emit) begin
        res_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ack_pop) begin
      res.last <= 1'b1;
      case (head.cmd.op)
        ACT_CREATE: begin
          res.kind       <= full ? KIND_ERR : KIND_ACK;
          res.status     <= full ? STAT_FULL : STAT_OK;
          res.fired_task <= full ? 3'd0 : 3'(task_count);
        end
        ACT_SET: begin
          res.kind       <= id_unknown ? KIND_ERR : KIND_ACK;
          res.status     <= id_unknown ? STAT_UNKNOWN : STAT_OK;
          res.fired_task <= head.cmd.id;
        end
        default: begin
          // tick: only the nothing-fired item comes from here
          res.kind       <= KIND_ACK;
          res.status     <= STAT_OK;
          res.fired_task <= 3'd0;
        end
      endcase
    end
    if (do_emit) begin
      res.kind       <= KIND_FIRE;
      res.status     <= STAT_OK;
      res.fired_task <= 3'(best_id);
      res.last       <= emit_last;
    end
  end

  // checks
  `PPT_ASSERT_SAME(a_emit_has_pick, state == ST_EMIT, best_valid && remain[best_id],
    "emit without a picked remaining task")
  `PPT_ASSERT_SAME(a_count_bound, 1'b1, task_count <= CNT_W'(MAX_TASKS),
    "task count beyond table size")
  `PPT_ASSERT_NEXT(a_more_follows,
    res_valid && res_ready && res.kind == KIND_FIRE && !res.last,
    res_valid || state != ST_IDLE,
    "dispatch ended before last item")
  `PPT_ASSERT_SAME(a_no_pop_busy, state != ST_IDLE, !pop,
    "command taken while a tick is in progress")

endmodule

`default_nettype wire

// File: rtl/core/priority_periodic_task_dispatcher_unit.sv
// ----------------------------------------------------------------------------
// priority_periodic_task_dispatcher_unit
// Fixed-priority periodic task table with create, set-priority and tick.
// ----------------------------------------------------------------------------
//
//   channel  signals                      carries
//   -------  ---------------------------  -----------------------------------
//   command  cmd_valid / cmd_ready / cmd  action, priority_req, period, task_id
//   result   res_valid / res_ready / res  kind, fired_task, status, last
//
// create and set priority take effect when the back end pops the item.
// a tick reloads and counts down all created tasks at once, then a scan of
// the priority table finds the next fired task in order, one entry per cycle,
// and an emit step sends it once the result register is free.
// a two-entry command queue takes items while results stall; cmd_ready
// drops once it holds two.
// reset clears the task count, the queue and res_valid; no clearing pass of the table.
//
`default_nettype none

module priority_periodic_task_dispatcher_unit #(
  parameter int MAX_TASKS = 8
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cmd_valid,
  output logic                    cmd_ready,
  input  wire ppt_pkg::in_item_t  cmd,
  output logic                    res_valid,
  input  wire logic               res_ready,
  output ppt_pkg::out_item_t      res
);
  import ppt_pkg::*;

  queue_head_t head;
  logic        pop;

  // front: accept and classify
  ppt_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .head      (head),
    .pop       (pop)
  );

  // back: table and dispatch
  ppt_back #(
    .MAX_TASKS (MAX_TASKS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .pop       (pop),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

endmodule

`default_nettype wire
